[src/emfrt_pkg.sv]
// Shared types and constants of the exact-match flow rule table.
package emfrt_pkg;

    // Default number of rule entries
    localparam int DEFAULT_TABLE_DEPTH = 64;

    // Field widths
    localparam int MAC_W      = 48;
    localparam int TYPE_W     = 16;
    localparam int ADDR_W     = 32;
    localparam int PROTO_W    = 8;
    localparam int L4PORT_W   = 16;
    localparam int INPORT_W   = 8;
    localparam int PRIO_W     = 16;
    localparam int ACTION_W   = 32;
    localparam int STATUS_W   = 2;
    localparam int ENTRY_NUM_W = 7;

    // Stream widths: request is 272 bits (34 bytes), result 9 bits padded to 16
    localparam int S_TDATA_W = 272;
    localparam int M_TDATA_W = 16;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_SAME     = 2'd0,
        ST_REPLACED = 2'd1,
        ST_ADDED    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // Exact-match key of one rule
    typedef struct packed {
        logic [MAC_W-1:0]    eth_src;
        logic [MAC_W-1:0]    eth_dst;
        logic [TYPE_W-1:0]   eth_type;
        logic [ADDR_W-1:0]   ip_src;
        logic [ADDR_W-1:0]   ip_dst;
        logic [PROTO_W-1:0]  ip_proto;
        logic [L4PORT_W-1:0] port_src;
        logic [L4PORT_W-1:0] port_dst;
        logic [INPORT_W-1:0] ingress_port;
    } rule_key_t;

    // One table row: key plus the non-key payload
    typedef struct packed {
        rule_key_t           key;
        logic [PRIO_W-1:0]   rule_priority;
        logic [ACTION_W-1:0] action_word;
    } rule_entry_t;

    // Result of one request
    typedef struct packed {
        status_t                  status;
        logic [ENTRY_NUM_W-1:0]   entry_number;
    } rule_result_t;

endpackage

[src/emfrt_table.sv]
// Rule storage: single write port, single read port, registered read data.
module emfrt_table
    import emfrt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_idx,
    output rule_entry_t      rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  rule_entry_t      wr_data
);

    rule_entry_t mem [TABLE_DEPTH];
    rule_entry_t rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
    end

    // Read port, registered; data holds when no read is issued
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/emfrt_ctrl.sv]
// Scan sequencer: walks occupied entries, resolves match/replace/append/full, holds result.
module emfrt_ctrl
    import emfrt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    // request side
    input  logic             in_valid,
    output logic             in_ready,
    input  rule_entry_t      in_rule,
    // result side
    output logic             out_valid,
    input  logic             out_ready,
    output rule_result_t     out_result,
    // table port
    output logic             rd_en,
    output logic [IDX_W-1:0] rd_idx,
    input  rule_entry_t      rd_data,
    output logic             wr_en,
    output logic [IDX_W-1:0] wr_idx,
    output rule_entry_t      wr_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    rule_entry_t         req_reg, req_next;
    logic [CNT_W-1:0]    used_reg, used_next;
    logic [CNT_W-1:0]    issue_reg, issue_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    rule_result_t        res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    rule_result_t        out_result_reg, out_result_next;

    logic                    hit;
    logic [CNT_W-1:0]        match_num;
    logic [ENTRY_NUM_W+CNT_W-1:0] match_num_ext;

    // Key compare against the entry read last cycle
    assign hit = cmp_valid_reg && (rd_data.key == req_reg.key);

    // Entry number is index plus one, cut to the result width
    assign match_num     = CNT_W'(cmp_idx_reg) + CNT_W'(1);
    assign match_num_ext = {{ENTRY_NUM_W{1'b0}}, match_num};

    assign in_ready = (state_reg == S_IDLE);

    // Next-state logic
    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        used_next       = used_reg;
        issue_next      = issue_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg;
        out_result_next = out_result_reg;
        rd_en           = 1'b0;
        rd_idx          = issue_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_idx          = cmp_idx_reg;
        wr_data         = req_reg;

        // result taken downstream
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    req_next   = in_rule;
                    issue_next = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    // first matching entry: keep or replace action
                    res_next.entry_number = match_num_ext[ENTRY_NUM_W-1:0];
                    if (rd_data.action_word == req_reg.action_word) begin
                        res_next.status = ST_SAME;
                    end else begin
                        wr_en                 = 1'b1;
                        wr_idx                = cmp_idx_reg;
                        wr_data               = rd_data;
                        wr_data.action_word   = req_reg.action_word;
                        res_next.status       = ST_REPLACED;
                    end
                    state_next = S_DONE;
                end else if (issue_reg != used_reg) begin
                    // stream the next occupied entry into the compare stage
                    rd_en          = 1'b1;
                    rd_idx         = issue_reg[IDX_W-1:0];
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_reg[IDX_W-1:0];
                    issue_next     = issue_reg + CNT_W'(1);
                end else begin
                    // no match: append or report full
                    res_next.entry_number = '0;
                    if (used_reg == CNT_W'(TABLE_DEPTH)) begin
                        res_next.status = ST_FULL;
                    end else begin
                        wr_en           = 1'b1;
                        wr_idx          = used_reg[IDX_W-1:0];
                        wr_data         = req_reg;
                        used_next       = used_reg + CNT_W'(1);
                        res_next.status = ST_ADDED;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next  = 1'b1;
                    out_result_next = res_reg;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
        req_reg        <= req_next;
        issue_reg      <= issue_next;
        cmp_idx_reg    <= cmp_idx_next;
        res_reg        <= res_next;
        out_result_reg <= out_result_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

    // Occupancy never passes the table size
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    // Occupancy only moves together with a table write
    a_used_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !wr_en |=> $stable(used_reg))
        else $error("entry count changed without a write");

    // Read and write never share a cycle
    a_rw_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> !rd_en)
        else $error("table read and write in the same cycle");

    // An accepted request starts a scan
    a_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (state_reg == S_SCAN))
        else $error("accepted request did not start a scan");

endmodule

[src/exact_match_flow_rule_table.sv]
// Exact-match flow rule table: stream request in, one status result out per request.
//
// Each request is a flow rule; the block scans occupied entries from entry 0 for the
// first exact key match (priority is not part of the key). A match with the same
// action returns status 0, a match with a different action rewrites the action and
// returns status 1; both report the entry index plus one. With no match the rule is
// appended (status 2, entry number 0), or, when all TABLE_DEPTH entries are taken,
// nothing is written (status 3, entry number 0). One request is in work at a time.
// The scan reads one entry per cycle through the single read port of the rule memory
// and compares the key on the registered read data, so it reads every occupied entry
// on a miss and the entries up to and including the matching one on a hit. The result
// sits in an output register, so a new request is accepted while the previous result
// still waits; its own result then stalls until that register is free.
module exact_match_flow_rule_table
    import emfrt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // eth_src[47:0], eth_dst[95:48], eth_type[111:96], ip_src[143:112],
    // ip_dst[175:144], ip_proto[183:176], port_src[199:184], port_dst[215:200],
    // ingress_port[223:216], rule_priority[239:224], action_word[271:240]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status[1:0], entry_number[8:2], zero[15:9]
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    rule_entry_t      in_rule;
    rule_result_t     out_result;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    rule_entry_t      rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    rule_entry_t      wr_data;

    // Unpack the request
    assign in_rule.key.eth_src      = s_tdata[47:0];
    assign in_rule.key.eth_dst      = s_tdata[95:48];
    assign in_rule.key.eth_type     = s_tdata[111:96];
    assign in_rule.key.ip_src       = s_tdata[143:112];
    assign in_rule.key.ip_dst       = s_tdata[175:144];
    assign in_rule.key.ip_proto     = s_tdata[183:176];
    assign in_rule.key.port_src     = s_tdata[199:184];
    assign in_rule.key.port_dst     = s_tdata[215:200];
    assign in_rule.key.ingress_port = s_tdata[223:216];
    assign in_rule.rule_priority    = s_tdata[239:224];
    assign in_rule.action_word      = s_tdata[271:240];

    // Pack the result
    assign m_tdata = {7'd0, out_result.entry_number, out_result.status};

    emfrt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_rule    (in_rule),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result),
        .rd_en      (rd_en),
        .rd_idx     (rd_idx),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_idx     (wr_idx),
        .wr_data    (wr_data)
    );

    emfrt_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_table (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_idx  (rd_idx),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data)
    );

endmodule
